// ----- design/assert_macros.svh -----
// Assertion macros used by the sorted array table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define SAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SAT_ASSERT(label, clk, rst_n, prop, msg)
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/sat_pkg.sv -----
// Package with the types and constants of the sorted array table.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int DEPTH       = 128;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = 7;
    localparam int OCC_W       = 8;
    localparam int CAP_W       = 8;
    localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_FIND
    } sat_op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_RANGE,
        ST_NOT_FOUND
    } sat_status_t;

    typedef struct packed {
        sat_op_t                        op;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic [IDX_W-1:0]               index;
    } sat_req_t;

    typedef struct packed {
        sat_status_t                    status;
        logic signed [VALUE_WIDTH-1:0]  data;
        logic [IDX_W-1:0]               position;
        logic [OCC_W-1:0]               occupancy;
    } sat_result_t;

endpackage

// ----- design/sat_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module sat_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/sat_ctrl.sv -----
// Sequencer that searches, shifts and updates the sorted entries in memory.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sat_ctrl
    import sat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  sat_req_t               req,
    input  logic [CAP_W-1:0]       capacity,
    output logic                   res_valid,
    input  logic                   res_take,
    output sat_result_t            res,
    output logic                   rd_en,
    output logic [ADDR_W-1:0]      rd_addr,
    input  logic [VALUE_WIDTH-1:0] rd_data,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_FIND_CHK,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    sat_op_t                       op_reg, op_next;
    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [CNT_W-1:0]              mid_reg, mid_next;
    logic [CNT_W-1:0]              ptr_reg, ptr_next;
    logic [ADDR_W-1:0]             last_reg, last_next;
    logic                          move_reg, move_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    sat_status_t                   status_reg, status_next;
    logic signed [VALUE_WIDTH-1:0] data_reg, data_next;
    logic [CNT_W-1:0]              pos_reg, pos_next;

    logic [CNT_W-1:0]              eff_cap;
    logic [CNT_W-1:0]              mid_calc;
    logic                          go_right;

    always_comb
    begin
        if (CMP_W'(capacity) > CMP_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity);
        end
    end

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            go_right = $signed(rd_data) <= value_reg;
        end
        else
        begin
            go_right = $signed(rd_data) < value_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        move_next   = move_reg;
        count_next  = count_reg;
        status_next = status_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    value_next  = req.value;
                    status_next = ST_OK;
                    data_next   = '0;
                    pos_next    = '0;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    unique case (req.op)
                        OP_INSERT:
                        begin
                            if (count_reg >= eff_cap)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SEARCH_RD;
                            end
                        end
                        OP_FIND:
                        begin
                            state_next = S_SEARCH_RD;
                        end
                        OP_REMOVE, OP_READ:
                        begin
                            if (CMP_W'(req.index) >= CMP_W'(count_reg))
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(req.index);
                                ptr_next   = CNT_W'(req.index) + CNT_W'(1);
                                state_next = S_LOAD;
                            end
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                data_next = $signed(rd_data);
                move_next = 1'b0;
                if (op_reg == OP_READ)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_DN;
                end
            end

            S_SHIFT_DN:
            begin
                if (move_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = last_reg - ADDR_W'(1);
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(ptr_reg);
                    last_next = ADDR_W'(ptr_reg);
                    move_next = 1'b1;
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    move_next = 1'b0;
                    if (!move_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_SEARCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(mid_calc);
                    mid_next   = mid_calc;
                    state_next = S_SEARCH_CMP;
                end
                else if (op_reg == OP_INSERT)
                begin
                    ptr_next   = count_reg;
                    move_next  = 1'b0;
                    state_next = S_SHIFT_UP;
                end
                else if (lo_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(lo_reg);
                    state_next = S_FIND_CHK;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_SEARCH_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH_RD;
            end

            S_FIND_CHK:
            begin
                if ($signed(rd_data) == value_reg)
                begin
                    pos_next = lo_reg;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
                state_next = S_DONE;
            end

            S_SHIFT_UP:
            begin
                if (move_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = last_reg + ADDR_W'(1);
                end
                if (ptr_reg > lo_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(ptr_reg - CNT_W'(1));
                    last_next = ADDR_W'(ptr_reg - CNT_W'(1));
                    move_next = 1'b1;
                    ptr_next  = ptr_reg - CNT_W'(1);
                end
                else
                begin
                    move_next = 1'b0;
                    if (!move_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(lo_reg);
                        wr_data    = value_reg;
                        count_next = count_reg + CNT_W'(1);
                        pos_next   = lo_reg;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            move_reg  <= move_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
    end

    assign req_stall     = (state_reg != S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.data      = data_reg;
    assign res.position  = IDX_W'(pos_reg);
    assign res.occupancy = OCC_W'(count_reg);

    `SAT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `SAT_ASSERT(a_idle_no_write, clk, rst_n, !(state_reg == S_IDLE && wr_en), "write while idle")
    `SAT_ASSERT(a_no_rw_clash, clk, rst_n, !(wr_en && rd_en && wr_addr == rd_addr), "read and write hit one entry")
    `SAT_ASSERT_NEXT(a_idle_count_hold, clk, rst_n, state_reg == S_IDLE, count_reg == $past(count_reg), "count changed without a request")

endmodule

// ----- design/sorted_array_table.sv -----
// Top level of the sorted array table: configuration, memory and result register.
//
//  Channel   Handshake                   Payload
//  request   req_valid / req_stall       operation, value, index
//  result    rsp_valid / rsp_stall       status, data, position, occupancy
//  config    cfg_we                      cfg_data (capacity limit)
//
// One request is worked at a time; the memory has one read and one write port and
// moves one entry per cycle. A read fetches the entry at its index; find is a binary
// search; insert is a binary search followed by shifting the higher entries up; remove
// shifts the entries above the index down.
// Reset empties the table at once; the entries themselves are not cleared.
// A new request is taken while the previous result waits in the output register.
`timescale 1ns / 1ps

module sorted_array_table
    import sat_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CAP_W-1:0]              cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [IDX_W-1:0]              index,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic signed [VALUE_WIDTH-1:0] data,
    output logic [IDX_W-1:0]              position,
    output logic [OCC_W-1:0]              occupancy
);

    logic [CAP_W-1:0]       cap_reg;
    logic                   out_valid_reg;
    sat_result_t            out_reg;

    sat_req_t               req;
    sat_result_t            res;
    logic                   res_valid;
    logic                   res_take;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    assign req.op    = sat_op_t'(operation);
    assign req.value = value;
    assign req.index = index;

    assign res_take = !out_valid_reg || !rsp_stall;

    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .capacity  (cap_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sat_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (res_take)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign data      = out_reg.data;
    assign position  = out_reg.position;
    assign occupancy = out_reg.occupancy;

endmodule
